/* rtl/lcdt_pkg.sv */
// Package with shared types and constants for the LCD mode timing and register block.
`timescale 1ns / 1ps
package lcdt_pkg;

  localparam int LAST_VISIBLE_LINE_DEF = 143;
  localparam int LAST_LINE_DEF         = 153;

  localparam logic [7:0] OAM_CLKS    = 8'd20;
  localparam logic [7:0] XFER_CLKS   = 8'd43;
  localparam logic [7:0] HBLANK_CLKS = 8'd51;
  localparam logic [7:0] VBLANK_CLKS = 8'd114;

  localparam int RAW_DEPTH = 16;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_t;

  localparam logic [3:0] REG_CTRL = 4'd0;
  localparam logic [3:0] REG_STAT = 4'd1;
  localparam logic [3:0] REG_SCY  = 4'd2;
  localparam logic [3:0] REG_SCX  = 4'd3;
  localparam logic [3:0] REG_LY   = 4'd4;
  localparam logic [3:0] REG_LYC  = 4'd5;

  typedef struct packed {
    lcd_mode_t  mode;
    logic [7:0] line;
  } status_t;

endpackage

/* rtl/lcdt_if.sv */
// Valid/ready channel interfaces for command items and result items.
`timescale 1ns / 1ps
interface lcdt_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] cycles;
  logic [3:0] reg_offset;
  logic [7:0] write_data;

  modport source (output valid, action, cycles, reg_offset, write_data, input ready);
  modport sink (input valid, action, cycles, reg_offset, write_data, output ready);
endinterface

interface lcdt_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] mode;
  logic [7:0] line;
  logic       vblank_irq;

  modport source (output valid, read_data, mode, line, vblank_irq, input ready);
  modport sink (input valid, read_data, mode, line, vblank_irq, output ready);
endinterface

/* rtl/lcdt_timing.sv */
// Mode counter, mode sequencer and scan line counter of the LCD timing.
`timescale 1ns / 1ps
module lcdt_timing #(
  parameter int LAST_VISIBLE_LINE = lcdt_pkg::LAST_VISIBLE_LINE_DEF,
  parameter int LAST_LINE         = lcdt_pkg::LAST_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic [3:0]        cycles,
  output lcdt_pkg::status_t status,
  output lcdt_pkg::status_t status_next,
  output logic              irq
);

  lcdt_pkg::lcd_mode_t mode, mode_next;
  logic [7:0] count, count_next;
  logic [7:0] line, line_next;
  logic [8:0] sum;
  logic [7:0] cnt;
  logic [8:0] line_inc;
  logic       irq_next;

  assign sum      = {1'b0, count} + {5'b0, cycles};
  assign cnt      = sum[8] ? 8'hFF : sum[7:0];
  assign line_inc = {1'b0, line} + 9'd1;

  always_comb begin
    mode_next  = mode;
    count_next = cnt;
    line_next  = line;
    irq_next   = 1'b0;
    case (mode)
      lcdt_pkg::MODE_HBLANK: begin
        if (cnt >= lcdt_pkg::HBLANK_CLKS) begin
          if (line == 8'(LAST_VISIBLE_LINE)) begin
            mode_next = lcdt_pkg::MODE_VBLANK;
            irq_next  = 1'b1;
          end else begin
            mode_next = lcdt_pkg::MODE_OAM;
          end
          line_next  = line_inc[7:0];
          count_next = 8'd0;
        end
      end
      lcdt_pkg::MODE_VBLANK: begin
        if (cnt >= lcdt_pkg::VBLANK_CLKS) begin
          count_next = 8'd0;
          if (line_inc > 9'(LAST_LINE)) begin
            line_next = 8'd0;
            mode_next = lcdt_pkg::MODE_OAM;
          end else begin
            line_next = line_inc[7:0];
          end
        end
      end
      lcdt_pkg::MODE_OAM: begin
        if (cnt >= lcdt_pkg::OAM_CLKS) begin
          count_next = 8'd0;
          mode_next  = lcdt_pkg::MODE_XFER;
        end
      end
      default: begin
        if (cnt >= lcdt_pkg::XFER_CLKS) begin
          count_next = 8'd0;
          mode_next  = lcdt_pkg::MODE_HBLANK;
        end
      end
    endcase
    if (!tick) begin
      mode_next  = mode;
      count_next = count;
      line_next  = line;
      irq_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= lcdt_pkg::MODE_OAM;
      count <= 8'd0;
      line  <= 8'd0;
    end else begin
      mode  <= mode_next;
      count <= count_next;
      line  <= line_next;
    end
  end

  assign status      = '{mode: mode, line: line};
  assign status_next = '{mode: mode_next, line: line_next};
  assign irq         = irq_next;

  // The counter always sits below the threshold of the mode it belongs to.
  assert property (@(posedge clk) disable iff (rst)
    (mode == lcdt_pkg::MODE_HBLANK && count < lcdt_pkg::HBLANK_CLKS) ||
    (mode == lcdt_pkg::MODE_VBLANK && count < lcdt_pkg::VBLANK_CLKS) ||
    (mode == lcdt_pkg::MODE_OAM && count < lcdt_pkg::OAM_CLKS) ||
    (mode == lcdt_pkg::MODE_XFER && count < lcdt_pkg::XFER_CLKS))
    else $error("mode counter at or above its threshold");

  // Timing state moves only on a tick.
  assert property (@(posedge clk) disable iff (rst)
    !tick |=> $stable(mode) && $stable(line) && $stable(count))
    else $error("timing state changed without a tick");

  // The interrupt fires only on the move from hblank into vblank.
  assert property (@(posedge clk) disable iff (rst)
    irq |-> mode == lcdt_pkg::MODE_HBLANK && mode_next == lcdt_pkg::MODE_VBLANK)
    else $error("interrupt outside the entry into vblank");

endmodule

/* rtl/lcd_mode_timing_registers.sv */
// Top level of the LCD mode timing and register window block.
// The block takes one item per clock cycle and presents its result item in the cycle after
// acceptance; every tick, read and write is done in a single registered update stage. The
// input is ready whenever the result register is empty or its item is taken in the same
// cycle, so items flow back to back while the receiver keeps up, and the input stalls for as
// long as a result waits to be taken.
`timescale 1ns / 1ps
module lcd_mode_timing_registers #(
  parameter int LAST_VISIBLE_LINE = lcdt_pkg::LAST_VISIBLE_LINE_DEF,
  parameter int LAST_LINE         = lcdt_pkg::LAST_LINE_DEF
) (
  input logic      clk,
  input logic      rst,
  lcdt_cmd_if.sink   cmd,
  lcdt_rsp_if.source rsp
);

  logic       accept;
  logic       is_tick;
  logic [7:0] rd_value;
  logic [5:0] control_flags;
  logic [7:0] scroll_y;
  logic [7:0] scroll_x;
  logic [7:0] compare_line;
  logic [7:0] raw_regs [lcdt_pkg::RAW_DEPTH];

  lcdt_pkg::status_t status, status_next;
  logic              irq;

  logic       out_valid;
  logic [7:0] out_read_data;
  logic [1:0] out_mode;
  logic [7:0] out_line;
  logic       out_irq;

  assign cmd.ready = !out_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_tick   = accept && (cmd.action == lcdt_pkg::ACT_TICK);

  lcdt_timing #(
    .LAST_VISIBLE_LINE(LAST_VISIBLE_LINE),
    .LAST_LINE(LAST_LINE)
  ) u_timing (
    .clk(clk),
    .rst(rst),
    .tick(is_tick),
    .cycles(cmd.cycles),
    .status(status),
    .status_next(status_next),
    .irq(irq)
  );

  always_comb begin
    case (cmd.reg_offset)
      lcdt_pkg::REG_CTRL: rd_value = {control_flags[5], 2'b00, control_flags[4:0]};
      lcdt_pkg::REG_STAT: rd_value = {5'b0, status.line == compare_line, status.mode};
      lcdt_pkg::REG_SCY:  rd_value = scroll_y;
      lcdt_pkg::REG_SCX:  rd_value = scroll_x;
      lcdt_pkg::REG_LY:   rd_value = status.line;
      lcdt_pkg::REG_LYC:  rd_value = compare_line;
      default:            rd_value = raw_regs[cmd.reg_offset];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_flags <= 6'h10;
      scroll_y      <= 8'd0;
      scroll_x      <= 8'd0;
      compare_line  <= 8'd0;
      for (int i = 0; i < lcdt_pkg::RAW_DEPTH; i++) begin
        raw_regs[i] <= 8'd0;
      end
    end else if (accept && cmd.action == lcdt_pkg::ACT_WRITE) begin
      raw_regs[cmd.reg_offset] <= cmd.write_data;
      case (cmd.reg_offset)
        lcdt_pkg::REG_CTRL: control_flags <= {cmd.write_data[7], cmd.write_data[4:0]};
        lcdt_pkg::REG_SCY:  scroll_y      <= cmd.write_data;
        lcdt_pkg::REG_SCX:  scroll_x      <= cmd.write_data;
        lcdt_pkg::REG_LYC:  compare_line  <= cmd.write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data <= (cmd.action == lcdt_pkg::ACT_READ) ? rd_value : 8'd0;
      out_mode      <= status_next.mode;
      out_line      <= status_next.line;
      out_irq       <= irq;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_read_data;
  assign rsp.mode       = out_mode;
  assign rsp.line       = out_line;
  assign rsp.vblank_irq = out_irq;

  // An interrupt result reports vblank on the line after the last visible one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_irq |->
      out_mode == lcdt_pkg::MODE_VBLANK && out_line == 8'(LAST_VISIBLE_LINE + 1))
    else $error("vblank interrupt with wrong mode or line");

  // Reads, writes and unused actions never raise the interrupt.
  assert property (@(posedge clk) disable iff (rst)
    accept && cmd.action != lcdt_pkg::ACT_TICK |=> !out_irq)
    else $error("interrupt raised by a non-tick item");

  // Only reads return data.
  assert property (@(posedge clk) disable iff (rst)
    accept && cmd.action != lcdt_pkg::ACT_READ |=> out_read_data == 8'd0)
    else $error("read data on a non-read item");

endmodule
